### sv/urb_pkg.sv
package urb_pkg;

	localparam int RX_DEPTH = 64;
	localparam int TX_DEPTH = 64;

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int TX_PW = $clog2(TX_DEPTH + 1);

	localparam int IN_DW  = 16;
	localparam int OUT_DW = 24;

	typedef enum logic [3:0] {
		ACT_RX_BYTE  = 4'd0,
		ACT_RX_READ  = 4'd1,
		ACT_RX_RESET = 4'd2,
		ACT_POLL     = 4'd3,
		ACT_TX_LOAD  = 4'd4,
		ACT_TX_CLEAR = 4'd5,
		ACT_TX_START = 4'd6,
		ACT_TX_SEND  = 4'd7,
		ACT_TX_CHECK = 4'd8
	} urb_act_t;

	typedef enum logic {
		ST_IDLE,
		ST_TX_CHK
	} urb_state_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clr;
		logic       poll;
		logic [7:0] data;
	} rx_req_t;

	typedef struct packed {
		logic avail;
		logic activity;
		logic overflow;
	} rx_rsp_t;

	typedef struct packed {
		logic       load;
		logic       clr;
		logic       start;
		logic       send;
		logic       commit;
		logic [7:0] data;
	} tx_req_t;

	typedef struct packed {
		logic       started;
		logic       draining;
		logic       busy_nx;
		logic [7:0] byte_out;
		logic       sent;
	} tx_sts_t;

	typedef struct packed {
		logic       tx_busy;
		logic       tx_done;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       overflow;
		logic       activity;
		logic       rx_valid;
	} res_t;

endpackage

### sv/urb_rx_ring.sv
module urb_rx_ring import urb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rx_req_t    req,
	output rx_rsp_t    rsp,
	output logic [7:0] rdata
);

	logic [7:0]       mem [RX_DEPTH];
	logic [RX_AW-1:0] wp_q, rp_q, wp_n, rp_n;
	logic             ovf_q, act_q;
	logic             full, avail, do_wr, do_rd;
	logic [7:0]       rdata_q;

	function automatic logic [RX_AW-1:0] nxt(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		wp_n  = nxt(wp_q);
		rp_n  = nxt(rp_q);
		// one slot always stays free
		full  = (wp_n == rp_q);
		avail = (rp_q != wp_q);
		do_wr = req.push && !ovf_q && !full;
		do_rd = req.pop && avail;
		rsp.avail    = avail;
		rsp.activity = act_q;
		if (req.clr) begin
			rsp.overflow = 1'b0;
		end else if (req.push && full) begin
			rsp.overflow = 1'b1;
		end else begin
			rsp.overflow = ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			ovf_q <= 1'b0;
			act_q <= 1'b0;
		end else begin
			ovf_q <= rsp.overflow;
			if (req.push) begin
				act_q <= 1'b1;
			end else if (req.poll) begin
				act_q <= 1'b0;
			end
			if (req.clr) begin
				wp_q <= '0;
				rp_q <= '0;
			end else begin
				if (do_wr) begin
					wp_q <= wp_n;
				end
				if (do_rd) begin
					rp_q <= rp_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wp_q] <= req.data;
		end
		if (do_rd) begin
			rdata_q <= mem[rp_q];
		end
	end

	assign rdata = rdata_q;

	a_ovf_blocks_write: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && !req.clr |=> $stable(wp_q))
		else $error("rx write position moved while overflow set");

	a_ring_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		req.push && full && !ovf_q |=> ovf_q)
		else $error("rx push into full ring did not flag overflow");

	a_read_avail: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop && !avail && !req.clr |=> $stable(rp_q))
		else $error("rx read position moved on empty ring");

endmodule

### sv/urb_tx_store.sv
module urb_tx_store import urb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  tx_req_t req,
	output tx_sts_t sts
);

	logic [7:0]          mem [TX_DEPTH];
	logic [TX_DEPTH-1:0] vld_q;
	logic [TX_PW-1:0]    wp_q, rp_q;
	logic                started_q, drain_q;
	logic [7:0]          rd_q;
	logic                rd_ok_q;
	logic                wp_in, rp_in, do_ld;
	logic [TX_AW-1:0]    wi, ri;
	logic [7:0]          rbyte;

	always_comb begin
		wp_in = (wp_q < TX_PW'(TX_DEPTH));
		rp_in = (rp_q < TX_PW'(TX_DEPTH));
		wi    = wp_q[TX_AW-1:0];
		ri    = rp_q[TX_AW-1:0];
		do_ld = req.load && wp_in;
		// entries never loaded since reset read as zero
		rbyte = rd_ok_q ? rd_q : 8'd0;
		sts.started  = started_q;
		sts.draining = drain_q;
		sts.byte_out = rbyte;
		sts.sent     = (rbyte != 8'd0);
		if (req.commit) begin
			sts.busy_nx = (rbyte != 8'd0);
		end else if (req.start) begin
			sts.busy_nx = 1'b1;
		end else begin
			sts.busy_nx = drain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			wp_q      <= '0;
			rp_q      <= '0;
			started_q <= 1'b0;
			drain_q   <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (do_ld) begin
				vld_q[wi] <= 1'b1;
				wp_q      <= wp_q + 1'b1;
			end
			if (req.clr) begin
				wp_q <= '0;
				rp_q <= '0;
			end
			if (req.start) begin
				started_q <= 1'b1;
				drain_q   <= 1'b1;
			end
			if (req.send) begin
				rd_ok_q <= rp_in && vld_q[ri];
			end
			if (req.commit) begin
				if (sts.sent) begin
					rp_q <= rp_q + 1'b1;
				end else begin
					// zero byte or end of store
					wp_q    <= '0;
					rp_q    <= '0;
					drain_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_ld) begin
			mem[wi] <= req.data;
		end
		if (req.send && rp_in) begin
			rd_q <= mem[ri];
		end
	end

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= TX_PW'(TX_DEPTH))
		else $error("tx write position past store end");

	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= TX_PW'(TX_DEPTH))
		else $error("tx read position past store end");

	a_commit_after_send: assert property (@(posedge clk) disable iff (!arst_n)
		req.commit |-> $past(req.send) && drain_q)
		else $error("tx commit without a preceding send read");

endmodule

### sv/uart_rx_ring_tx_linear_buffer_core.sv
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: data, shift_empty; tuser: action
// m_*      out  m_tvalid/m_tready  tdata: rx/tx result fields, flags
//
// Most actions update state at the accept edge; the result goes via the result stage.
// A send while draining enters ST_TX_CHK: the tx store read decides whether the byte is sent.
// Rx read data comes from the ring memory, registered at the accept edge.
// An output register and one result stage let a new item enter while a result waits.
// Reset clears positions, flags and the tx valid bits at once; no clearing pass.
module uart_rx_ring_tx_linear_buffer_core import urb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,  // [7:0] data, [8] shift_empty, [15:9] zero
	input  logic [3:0]        s_tuser,  // [3:0] action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata   // [7:0] rx_byte, [8] rx_valid, [9] activity,
	                                    // [10] overflow, [18:11] tx_byte, [19] tx_valid,
	                                    // [20] tx_done, [21] tx_busy, [23:22] zero
);

	urb_state_t state_q, state_d;
	urb_act_t   act;
	logic       acc, mv, send_chk, load_s1;
	logic       v_s1;
	res_t       res_s1, res;
	rx_req_t    rx_req;
	rx_rsp_t    rx_rsp;
	logic [7:0] rx_rdata;
	tx_req_t    tx_req;
	tx_sts_t    tx_sts;
	logic       m_tvalid_q;
	logic [OUT_DW-1:0] m_tdata_q;
	logic [7:0] rx_byte;

	assign act      = urb_act_t'(s_tuser);
	assign mv       = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && (!v_s1 || mv);
	assign acc      = s_tvalid && s_tready;
	assign send_chk = acc && (act == ACT_TX_SEND) && tx_sts.draining;

	always_comb begin
		rx_req.push = acc && (act == ACT_RX_BYTE);
		rx_req.pop  = acc && (act == ACT_RX_READ);
		rx_req.clr  = acc && (act == ACT_RX_RESET);
		rx_req.poll = acc && (act == ACT_POLL);
		rx_req.data = s_tdata[7:0];

		tx_req.load   = acc && (act == ACT_TX_LOAD);
		tx_req.clr    = acc && (act == ACT_TX_CLEAR);
		tx_req.start  = acc && (act == ACT_TX_START);
		tx_req.send   = send_chk;
		tx_req.commit = (state_q == ST_TX_CHK);
		tx_req.data   = s_tdata[7:0];
	end

	urb_rx_ring u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rx_req),
		.rsp    (rx_rsp),
		.rdata  (rx_rdata)
	);

	urb_tx_store u_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tx_req),
		.sts    (tx_sts)
	);

	always_comb begin
		state_d = state_q;
		load_s1 = 1'b0;
		res     = '0;
		res.overflow = rx_rsp.overflow;
		res.tx_busy  = tx_sts.busy_nx;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (send_chk) begin
						state_d = ST_TX_CHK;
					end else begin
						load_s1 = 1'b1;
					end
				end
				res.rx_valid = rx_req.pop && rx_rsp.avail;
				res.activity = rx_req.poll && rx_rsp.activity;
				res.tx_done  = acc && (act == ACT_TX_CHECK) &&
				               (!tx_sts.started || (!tx_sts.draining && s_tdata[8]));
			end
			ST_TX_CHK: begin
				load_s1      = 1'b1;
				res.tx_byte  = tx_sts.byte_out;
				res.tx_valid = tx_sts.sent;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= 1'b1;
		end else if (mv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			res_s1 <= res;
		end
	end

	// ring read data is held until the next read, which cannot enter before this stage moves
	assign rx_byte = res_s1.rx_valid ? rx_rdata : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (mv) begin
			m_tvalid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv && v_s1) begin
			m_tdata_q <= {2'b00, res_s1.tx_busy, res_s1.tx_done, res_s1.tx_valid,
			              res_s1.tx_byte, res_s1.overflow, res_s1.activity,
			              res_s1.rx_valid, rx_byte};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_chk_stage_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TX_CHK |-> !v_s1)
		else $error("result stage occupied during tx check");

	a_chk_from_send: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TX_CHK |-> $past(send_chk))
		else $error("tx check entered without a send");

	a_sent_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 && res.tx_valid |-> res.tx_byte != 8'd0)
		else $error("zero byte reported as sent");

endmodule
